/* rtl/bcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the 2d barycentric coordinate pipeline.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int COORD_BITS  = 12;
	localparam int FRAC_BITS   = 16;
	localparam int WEIGHT_BITS = 20;

	// edge vector, product and cross product widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = CROSS_W;

	// rounded dividend: |num| << FRAC_BITS plus half the divisor
	localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_W      = DIV_STAGES * DIV_STEPS;

	// signed quotient and the wider sum used for u
	localparam int SQ_W = DIV_W + 1;
	localparam int U_W  = SQ_W + 2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] vert_a_x;
		logic signed [COORD_BITS-1:0] vert_a_y;
		logic signed [COORD_BITS-1:0] vert_b_x;
		logic signed [COORD_BITS-1:0] vert_b_y;
		logic signed [COORD_BITS-1:0] vert_c_x;
		logic signed [COORD_BITS-1:0] vert_c_y;
	} in_t;

	typedef struct packed {
		logic signed [WEIGHT_BITS-1:0] weight_u;
		logic signed [WEIGHT_BITS-1:0] weight_v;
		logic signed [WEIGHT_BITS-1:0] weight_w;
		logic                          degenerate;
		logic                          saturated;
	} out_t;

	// sign and degenerate info riding alongside the divider
	typedef struct packed {
		logic neg_v;
		logic neg_w;
		logic degen;
	} side_t;

endpackage

/* rtl/bcc_cross.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_cross
// Edge vectors, cross products, magnitudes and rounded dividends (5 stages).
// ----------------------------------------------------------------------------
module bcc_cross (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  bcc_pkg::in_t                   query,
	output logic                           out_valid,
	output logic [bcc_pkg::NUM_W-1:0]      num_v,
	output logic [bcc_pkg::NUM_W-1:0]      num_w,
	output logic [bcc_pkg::MAG_W-1:0]      den,
	output bcc_pkg::side_t                 side
);
	import bcc_pkg::*;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [DIFF_W-1:0] e0x_s1, e0y_s1, e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [PROD_W-1:0] dpa_s2, dpb_s2, vpa_s2, vpb_s2, wpa_s2, wpb_s2;
	logic signed [CROSS_W-1:0] det_s3, nv_s3, nw_s3;
	logic [MAG_W-1:0]         dmag_s4, vmag_s4, wmag_s4;
	side_t                    side_s4, side_s5;
	logic [NUM_W-1:0]         num_v_s5, num_w_s5;
	logic [MAG_W-1:0]         den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		e0x_s1 <= DIFF_W'(query.vert_b_x) - DIFF_W'(query.vert_a_x);
		e0y_s1 <= DIFF_W'(query.vert_b_y) - DIFF_W'(query.vert_a_y);
		e1x_s1 <= DIFF_W'(query.vert_c_x) - DIFF_W'(query.vert_a_x);
		e1y_s1 <= DIFF_W'(query.vert_c_y) - DIFF_W'(query.vert_a_y);
		e2x_s1 <= DIFF_W'(query.point_x) - DIFF_W'(query.vert_a_x);
		e2y_s1 <= DIFF_W'(query.point_y) - DIFF_W'(query.vert_a_y);

		dpa_s2 <= e0x_s1 * e1y_s1;
		dpb_s2 <= e0y_s1 * e1x_s1;
		vpa_s2 <= e2x_s1 * e1y_s1;
		vpb_s2 <= e2y_s1 * e1x_s1;
		wpa_s2 <= e0x_s1 * e2y_s1;
		wpb_s2 <= e0y_s1 * e2x_s1;

		det_s3 <= CROSS_W'(dpa_s2) - CROSS_W'(dpb_s2);
		nv_s3  <= CROSS_W'(vpa_s2) - CROSS_W'(vpb_s2);
		nw_s3  <= CROSS_W'(wpa_s2) - CROSS_W'(wpb_s2);

		dmag_s4 <= det_s3[CROSS_W-1] ? MAG_W'(~det_s3 + 1'b1) : MAG_W'(det_s3);
		vmag_s4 <= nv_s3[CROSS_W-1] ? MAG_W'(~nv_s3 + 1'b1) : MAG_W'(nv_s3);
		wmag_s4 <= nw_s3[CROSS_W-1] ? MAG_W'(~nw_s3 + 1'b1) : MAG_W'(nw_s3);
		side_s4.neg_v <= nv_s3[CROSS_W-1] ^ det_s3[CROSS_W-1];
		side_s4.neg_w <= nw_s3[CROSS_W-1] ^ det_s3[CROSS_W-1];
		side_s4.degen <= (det_s3 == '0);

		// round half away from zero: add half the divisor before dividing
		num_v_s5 <= (NUM_W'(vmag_s4) << FRAC_BITS) + NUM_W'(dmag_s4 >> 1);
		num_w_s5 <= (NUM_W'(wmag_s4) << FRAC_BITS) + NUM_W'(dmag_s4 >> 1);
		den_s5   <= dmag_s4;
		side_s5  <= side_s4;
	end

	assign out_valid = vld_s5;
	assign num_v     = num_v_s5;
	assign num_w     = num_w_s5;
	assign den       = den_s5;
	assign side      = side_s5;

endmodule

/* rtl/bcc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider, two quotients sharing one divisor,
// DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module bcc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [bcc_pkg::NUM_W-1:0]      num_v,
	input  logic [bcc_pkg::NUM_W-1:0]      num_w,
	input  logic [bcc_pkg::MAG_W-1:0]      den,
	input  bcc_pkg::side_t                 side_in,
	output logic                           out_valid,
	output logic [bcc_pkg::DIV_W-1:0]      quot_v,
	output logic [bcc_pkg::DIV_W-1:0]      quot_w,
	output bcc_pkg::side_t                 side_out
);
	import bcc_pkg::*;

	logic             vld_sn   [DIV_STAGES+1];
	logic [MAG_W-1:0] den_sn   [DIV_STAGES+1];
	side_t            side_sn  [DIV_STAGES+1];
	logic [MAG_W-1:0] rem_v_sn [DIV_STAGES+1];
	logic [MAG_W-1:0] rem_w_sn [DIV_STAGES+1];
	logic [DIV_W-1:0] num_v_sn [DIV_STAGES+1];
	logic [DIV_W-1:0] num_w_sn [DIV_STAGES+1];
	logic [DIV_W-1:0] quo_v_sn [DIV_STAGES+1];
	logic [DIV_W-1:0] quo_w_sn [DIV_STAGES+1];

	// one restoring step: {quotient bit, new remainder}
	function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
		input logic nb, input logic [MAG_W-1:0] dv);
		logic [MAG_W:0] t;
		logic [MAG_W:0] d;
		t = {rem, nb};
		d = {1'b0, dv};
		if (t >= d) begin
			return {1'b1, MAG_W'(t - d)};
		end
		return {1'b0, t[MAG_W-1:0]};
	endfunction

	assign vld_sn[0]   = in_valid;
	assign den_sn[0]   = den;
	assign side_sn[0]  = side_in;
	assign rem_v_sn[0] = '0;
	assign rem_w_sn[0] = '0;
	assign num_v_sn[0] = DIV_W'(num_v);
	assign num_w_sn[0] = DIV_W'(num_w);
	assign quo_v_sn[0] = '0;
	assign quo_w_sn[0] = '0;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [MAG_W-1:0] rv, rw;
		logic [DIV_W-1:0] nv, nw, qv, qw;
		logic [MAG_W:0]   sv, sw;

		always_comb begin
			rv = rem_v_sn[g];
			rw = rem_w_sn[g];
			nv = num_v_sn[g];
			nw = num_w_sn[g];
			qv = quo_v_sn[g];
			qw = quo_w_sn[g];
			sv = '0;
			sw = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				sv = div_step(rv, nv[DIV_W-1], den_sn[g]);
				sw = div_step(rw, nw[DIV_W-1], den_sn[g]);
				rv = sv[MAG_W-1:0];
				rw = sw[MAG_W-1:0];
				qv = {qv[DIV_W-2:0], sv[MAG_W]};
				qw = {qw[DIV_W-2:0], sw[MAG_W]};
				nv = nv << 1;
				nw = nw << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[g+1] <= 1'b0;
			end else begin
				vld_sn[g+1] <= vld_sn[g];
			end
		end

		always_ff @(posedge clk) begin
			den_sn[g+1]   <= den_sn[g];
			side_sn[g+1]  <= side_sn[g];
			rem_v_sn[g+1] <= rv;
			rem_w_sn[g+1] <= rw;
			num_v_sn[g+1] <= nv;
			num_w_sn[g+1] <= nw;
			quo_v_sn[g+1] <= qv;
			quo_w_sn[g+1] <= qw;
		end
	end

	assign out_valid = vld_sn[DIV_STAGES];
	assign quot_v    = quo_v_sn[DIV_STAGES];
	assign quot_w    = quo_w_sn[DIV_STAGES];
	assign side_out  = side_sn[DIV_STAGES];

	// valid bits march through the divider without gaps or extras
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid == $past(in_valid, DIV_STAGES))
		else $error("divider valid latency mismatch");

endmodule

/* rtl/bcc_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_out
// Applies signs, forms u, clamps the weights and registers the result (3 stages).
// ----------------------------------------------------------------------------
module bcc_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [bcc_pkg::DIV_W-1:0]      quot_v,
	input  logic [bcc_pkg::DIV_W-1:0]      quot_w,
	input  bcc_pkg::side_t                 side,
	output logic                           done,
	output bcc_pkg::out_t                  result
);
	import bcc_pkg::*;

	localparam logic signed [U_W-1:0] ONE_FX = U_W'(1) << FRAC_BITS;
	localparam logic signed [U_W-1:0] W_HI   = U_W'((1 << (WEIGHT_BITS - 1)) - 1);
	localparam logic signed [U_W-1:0] W_LO   = -W_HI - U_W'(1);
	localparam logic [WEIGHT_BITS-1:0] W_MAX = W_HI[WEIGHT_BITS-1:0];
	localparam logic [WEIGHT_BITS-1:0] W_MIN = W_LO[WEIGHT_BITS-1:0];

	logic                   vld_s1, vld_s2, vld_s3;
	logic signed [SQ_W-1:0] v_s1, w_s1;
	logic                   degen_s1, degen_s2;
	logic signed [U_W-1:0]  u_s2, v_s2, w_s2;
	out_t                   res_s3;
	logic [WEIGHT_BITS:0]   cu, cv, cw;

	// {clamped flag, clamped value}
	function automatic logic [WEIGHT_BITS:0] clamp(input logic signed [U_W-1:0] x);
		if (x > W_HI) begin
			return {1'b1, W_MAX};
		end
		if (x < W_LO) begin
			return {1'b1, W_MIN};
		end
		return {1'b0, x[WEIGHT_BITS-1:0]};
	endfunction

	assign cu = clamp(u_s2);
	assign cv = clamp(v_s2);
	assign cw = clamp(w_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s1     <= side.neg_v ? -$signed({1'b0, quot_v}) : $signed({1'b0, quot_v});
		w_s1     <= side.neg_w ? -$signed({1'b0, quot_w}) : $signed({1'b0, quot_w});
		degen_s1 <= side.degen;

		// u from the rounded, not yet clamped v and w
		u_s2     <= ONE_FX - U_W'(v_s1) - U_W'(w_s1);
		v_s2     <= U_W'(v_s1);
		w_s2     <= U_W'(w_s1);
		degen_s2 <= degen_s1;

		if (degen_s2) begin
			res_s3.weight_u   <= '0;
			res_s3.weight_v   <= '0;
			res_s3.weight_w   <= '0;
			res_s3.degenerate <= 1'b1;
			res_s3.saturated  <= 1'b0;
		end else begin
			res_s3.weight_u   <= cu[WEIGHT_BITS-1:0];
			res_s3.weight_v   <= cv[WEIGHT_BITS-1:0];
			res_s3.weight_w   <= cw[WEIGHT_BITS-1:0];
			res_s3.degenerate <= 1'b0;
			res_s3.saturated  <= cu[WEIGHT_BITS] | cv[WEIGHT_BITS] | cw[WEIGHT_BITS];
		end
	end

	assign done   = vld_s3;
	assign result = res_s3;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && res_s3.degenerate |-> !res_s3.saturated && res_s3.weight_u == '0
			&& res_s3.weight_v == '0 && res_s3.weight_w == '0)
		else $error("degenerate item with nonzero weights or saturation");

	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && res_s3.saturated |->
			res_s3.weight_u == W_MAX || res_s3.weight_u == W_MIN ||
			res_s3.weight_v == W_MAX || res_s3.weight_v == W_MIN ||
			res_s3.weight_w == W_MAX || res_s3.weight_w == W_MIN)
		else $error("saturated item with no weight at a bound");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_valid, 3))
		else $error("result strobe without an item three cycles back");

endmodule

/* rtl/barycentric_coords_2d_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_coords_2d_top
// Barycentric weights of a 2d point in a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// One item may be started every clock cycle; busy is never raised. Each item
// gives exactly one result, marked by done, after it has passed through edge
// and cross product setup, the pipelined divider at two quotient bits per
// stage, and sign, u and clamping.
// Results come out in start order and must be taken in the cycle they appear.
module barycentric_coords_2d_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bcc_pkg::in_t    query,
	output logic            done,
	output bcc_pkg::out_t   result
);
	import bcc_pkg::*;

	logic             x_valid, d_valid;
	logic [NUM_W-1:0] x_num_v, x_num_w;
	logic [MAG_W-1:0] x_den;
	side_t            x_side, d_side;
	logic [DIV_W-1:0] d_quot_v, d_quot_w;

	assign busy = 1'b0;

	bcc_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.query     (query),
		.out_valid (x_valid),
		.num_v     (x_num_v),
		.num_w     (x_num_w),
		.den       (x_den),
		.side      (x_side)
	);

	bcc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (x_valid),
		.num_v     (x_num_v),
		.num_w     (x_num_w),
		.den       (x_den),
		.side_in   (x_side),
		.out_valid (d_valid),
		.quot_v    (d_quot_v),
		.quot_w    (d_quot_w),
		.side_out  (d_side)
	);

	bcc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.quot_v   (d_quot_v),
		.quot_w   (d_quot_w),
		.side     (d_side),
		.done     (done),
		.result   (result)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the 2d barycentric weight pipeline. Items are sent with
// random gaps, every result is compared field by field against weights
// computed here from exact integer cross products.
// ----------------------------------------------------------------------------
module tb_top;
	import bcc_pkg::*;

	localparam int LATENCY   = 30;
	localparam int MAX_CYCLE = 400000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	in_t   query = '0;
	logic  done;
	out_t  result;

	int    gap_pct = 0;
	int    errors = 0;
	int    cycles = 0;
	out_t  weights_due[$];

	barycentric_coords_2d_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query(query), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	// round(num * 2^FRAC_BITS / den), halves away from zero
	function automatic longint scaled_ratio(longint num, longint den);
		longint an, ad, q;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = ((an <<< FRAC_BITS) + ad / 2) / ad;
		return (((num < 0) != (den < 0)) ? -q : q);
	endfunction

	function automatic out_t weights_of(in_t q);
		longint e0x, e0y, e1x, e1y, e2x, e2y, det, v, w, u, hi, lo;
		out_t r;
		e0x = longint'(q.vert_b_x) - longint'(q.vert_a_x);
		e0y = longint'(q.vert_b_y) - longint'(q.vert_a_y);
		e1x = longint'(q.vert_c_x) - longint'(q.vert_a_x);
		e1y = longint'(q.vert_c_y) - longint'(q.vert_a_y);
		e2x = longint'(q.point_x) - longint'(q.vert_a_x);
		e2y = longint'(q.point_y) - longint'(q.vert_a_y);
		det = e0x * e1y - e0y * e1x;
		r = '0;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		v = scaled_ratio(e2x * e1y - e2y * e1x, det);
		w = scaled_ratio(e0x * e2y - e0y * e2x, det);
		u = (longint'(1) <<< FRAC_BITS) - v - w;
		hi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
		lo = -hi - 1;
		if (u > hi || u < lo || v > hi || v < lo || w > hi || w < lo)
			r.saturated = 1'b1;
		r.weight_u = WEIGHT_BITS'((u > hi) ? hi : (u < lo) ? lo : u);
		r.weight_v = WEIGHT_BITS'((v > hi) ? hi : (v < lo) ? lo : v);
		r.weight_w = WEIGHT_BITS'((w > hi) ? hi : (w < lo) ? lo : w);
		return r;
	endfunction

	task automatic send_query(in_t q);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		query <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		weights_due.push_back(weights_of(q));
	endtask

	task automatic go_idle();
		start <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// sampled at the edge, after the block's outputs settled in the prior step
	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			if (weights_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", result);
			end else begin
				want = weights_due.pop_front();
				if (result.weight_u !== want.weight_u || result.weight_v !== want.weight_v
						|| result.weight_w !== want.weight_w
						|| result.degenerate !== want.degenerate
						|| result.saturated !== want.saturated) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: want u=%0d v=%0d w=%0d dg=%b st=%b",
							" got u=%0d v=%0d w=%0d dg=%b st=%b"},
							want.weight_u, want.weight_v, want.weight_w, want.degenerate,
							want.saturated, result.weight_u, result.weight_v,
							result.weight_w, result.degenerate, result.saturated);
				end
			end
		end
	end

	function automatic in_t make_query(int px, int py, int ax, int ay, int bx, int by,
			int cx, int cy);
		in_t q;
		q.point_x = COORD_BITS'(px); q.point_y = COORD_BITS'(py);
		q.vert_a_x = COORD_BITS'(ax); q.vert_a_y = COORD_BITS'(ay);
		q.vert_b_x = COORD_BITS'(bx); q.vert_b_y = COORD_BITS'(by);
		q.vert_c_x = COORD_BITS'(cx); q.vert_c_y = COORD_BITS'(cy);
		return q;
	endfunction

	function automatic int rand_coord();
		return $urandom_range(4095) - 2048;
	endfunction

	task automatic test_directed();
		send_query(make_query(0, 0, 0, 0, 16, 0, 0, 16));
		send_query(make_query(16, 0, 0, 0, 16, 0, 0, 16));
		send_query(make_query(0, 16, 0, 0, 16, 0, 0, 16));
		send_query(make_query(5, 5, 0, 0, 16, 0, 0, 16));
		// halfway rounding and negative weights outside the triangle
		send_query(make_query(-1, 1, 0, 0, 2, 0, 0, 2));
		send_query(make_query(1, 1, 0, 0, 3, 0, 0, 3));
		send_query(make_query(-7, -9, 0, 0, 3, 0, 0, -3));
		// degenerate: collinear and coincident vertices
		send_query(make_query(3, 3, 0, 0, 1, 1, 2, 2));
		send_query(make_query(0, 0, 7, 7, 7, 7, 7, 7));
		send_query(make_query(-2048, -2048, -2048, -2048, -2048, -2048, 2047, 2047));
		// tiny triangle with far point saturates
		send_query(make_query(2047, 2047, 0, 0, 1, 0, 0, 1));
		send_query(make_query(-2048, -2048, 0, 0, 1, 0, 0, 1));
		send_query(make_query(-2048, 2047, 2047, -2048, 2046, -2048, 2047, -2047));
		// full range triangle
		send_query(make_query(0, 0, -2048, -2048, 2047, -2048, -2048, 2047));
		send_query(make_query(2047, 2047, -2048, -2048, 2047, -2048, -2048, 2047));
		send_query(make_query(-2048, 2047, 2047, 2047, -2048, -2048, 2047, -2048));
		send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1));
		// clockwise winding
		send_query(make_query(4, 4, 0, 0, 0, 16, 16, 0));
	endtask

	task automatic test_random(int n);
		int ax, ay, s;
		for (int i = 0; i < n; i++) begin
			ax = rand_coord(); ay = rand_coord();
			case ($urandom_range(3))
				0: send_query(make_query(rand_coord(), rand_coord(), ax, ay, rand_coord(),
					rand_coord(), rand_coord(), rand_coord()));
				1: begin
					// small triangle near A, point anywhere
					s = $urandom_range(8);
					send_query(make_query(rand_coord(), rand_coord(), ax, ay,
						ax + $urandom_range(s), ay - $urandom_range(s),
						ax - $urandom_range(s), ay + $urandom_range(s)));
				end
				2: begin
					// collinear
					s = $urandom_range(20) - 10;
					send_query(make_query(rand_coord(), rand_coord(), 0, 0, s, 2 * s,
						-3 * s, -6 * s));
				end
				default: begin
					// point near vertex A of a moderate triangle
					send_query(make_query(ax + $urandom_range(200) - 100,
						ay + $urandom_range(200) - 100, ax, ay,
						ax + $urandom_range(200), ay, ax, ay + $urandom_range(200)));
				end
			endcase
		end
	endtask

	initial begin
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 6;
		test_directed();
		test_random(230);
		gap_pct = 86;
		test_random(230);
		gap_pct = 0;
		test_random(230);
		go_idle();
		waited = 0;
		while (weights_due.size() != 0 && waited < 10 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && weights_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/bcc_pkg.sv
rtl/bcc_cross.sv
rtl/bcc_div.sv
rtl/bcc_out.sv
rtl/barycentric_coords_2d_top.sv
tb/tb_top.sv
